// ===== hw/rtl/mof_pkg.sv =====
// Package for the median offset filter with outlier gate.
// Holds window size, register indexes, reset values and shared types.
// No dependencies.
package mof_pkg;

  localparam int WINDOW_SIZE = 8;
  localparam int SAMPLE_W    = 64;
  localparam int CNT_W       = $clog2(WINDOW_SIZE + 1);
  localparam int MAX_JUMP_W  = 32;
  localparam int CONFIRM_W   = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int FLAGS_W     = 4;

  localparam logic [CNT_W-1:0] WIN_CNT  = CNT_W'(WINDOW_SIZE);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(WINDOW_SIZE - 1);
  localparam logic [CNT_W-1:0] MED_LT   = CNT_W'(WINDOW_SIZE / 2);
  localparam logic [CNT_W-1:0] MED_LE   = CNT_W'(WINDOW_SIZE / 2 + 1);

  localparam logic [MAX_JUMP_W-1:0] MAX_JUMP_RESET = MAX_JUMP_W'(180000);
  localparam logic [CONFIRM_W-1:0]  CONFIRM_RESET  = CONFIRM_W'(3);
  localparam logic [CONFIRM_W-1:0]  STREAK_MAX     = CONFIRM_W'(255);

  localparam logic [CFG_IDX_W-1:0] REG_MAX_JUMP = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CONFIRM  = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SORT,
    ST_PICK,
    ST_OUT
  } mof_state_t;

  typedef struct packed {
    logic fill;
    logic shift;
    logic load;
    logic step;
  } mof_cell_ctl_t;

  typedef struct packed {
    logic reanchored;
    logic outlier_ignored;
    logic offset_updated;
    logic filter_ready;
  } mof_flags_t;

endpackage

// ===== hw/rtl/mof_cell.sv =====
// One window cell: holds a sample, passes a rotating copy to its neighbor
// and counts how many rotating values lie below or at its own sample.
// Depends on mof_pkg.
module mof_cell import mof_pkg::*; (
  input  logic                       clk,
  input  mof_cell_ctl_t              ctl,
  input  logic signed [SAMPLE_W-1:0] fill_val,
  input  logic signed [SAMPLE_W-1:0] w_prev,
  input  logic signed [SAMPLE_W-1:0] m_prev,
  output logic signed [SAMPLE_W-1:0] w,
  output logic signed [SAMPLE_W-1:0] m,
  output logic                       is_med
);

  logic signed [SAMPLE_W-1:0] w_r, w_nxt;
  logic signed [SAMPLE_W-1:0] m_r, m_nxt;
  logic [CNT_W-1:0]           lt_r, lt_nxt;
  logic [CNT_W-1:0]           le_r, le_nxt;

  always_comb begin
    if (ctl.fill) begin
      w_nxt = fill_val;
    end else if (ctl.shift) begin
      w_nxt = w_prev;
    end else begin
      w_nxt = w_r;
    end
  end

  always_comb begin
    m_nxt  = m_r;
    lt_nxt = lt_r;
    le_nxt = le_r;
    if (ctl.load) begin
      m_nxt  = w_nxt;
      lt_nxt = '0;
      le_nxt = '0;
    end else if (ctl.step) begin
      m_nxt  = m_prev;
      lt_nxt = lt_r + CNT_W'(m_r <  w_r);
      le_nxt = le_r + CNT_W'(m_r <= w_r);
    end
  end

  always_ff @(posedge clk) begin
    w_r  <= w_nxt;
    m_r  <= m_nxt;
    lt_r <= lt_nxt;
    le_r <= le_nxt;
  end

  assign w      = w_r;
  assign m      = m_r;
  assign is_med = (lt_r <= MED_LT) && (le_r >= MED_LE);

endmodule

// ===== hw/rtl/median_offset_filter_outlier_gate.sv =====
// Median offset filter with outlier gate: a row of cells holds the window.
// An outlier or a partly filled window goes from ST_EVAL straight to ST_OUT; when a median
// is selected, ST_SORT and ST_PICK come between them, and the rank count rotates the window
// once through the cell row, one cell per cycle. One request at a time: the next is taken
// only after the last result has been loaded into the output register, which waits while
// the output stalls. Reset (rst_n low, synchronous) empties the window, clears the
// held offset and streak and restores the register reset values.
module median_offset_filter_outlier_gate import mof_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [SAMPLE_W-1:0]   in_tdata,   // [63:0] offset_sample
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [SAMPLE_W-1:0]   out_tdata,  // [63:0] current_offset
  output logic [FLAGS_W-1:0]    out_tuser,  // [0] filter_ready, [1] offset_updated,
                                            // [2] outlier_ignored, [3] reanchored
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  mof_state_t state_r, state_nxt;

  logic [MAX_JUMP_W-1:0]      max_jump_r;
  logic [CONFIRM_W-1:0]       confirm_r;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic signed [SAMPLE_W-1:0] held_r, held_nxt;
  logic [CONFIRM_W-1:0]       streak_r, streak_nxt;
  logic [CNT_W-1:0]           fill_r, fill_nxt;
  logic                       ready_r, ready_nxt;
  logic [CNT_W-1:0]           sort_cnt_r, sort_cnt_nxt;
  mof_flags_t                 flags_r, flags_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0]        out_data_r, out_data_nxt;
  mof_flags_t                 out_flags_r, out_flags_nxt;

  mof_cell_ctl_t              cell_ctl;
  logic signed [SAMPLE_W-1:0] cell_w   [WINDOW_SIZE];
  logic signed [SAMPLE_W-1:0] cell_m   [WINDOW_SIZE];
  logic                       cell_med [WINDOW_SIZE];
  logic signed [SAMPLE_W-1:0] median;

  logic signed [SAMPLE_W:0]   diff;
  logic [SAMPLE_W:0]          abs_diff;
  logic                       outlier;
  logic [CONFIRM_W-1:0]       streak_inc;
  logic [CNT_W-1:0]           fill_sat;
  logic                       out_load;

  // cell row
  for (genvar i = 0; i < WINDOW_SIZE; i++) begin : g_cell
    logic signed [SAMPLE_W-1:0] w_prev;
    logic signed [SAMPLE_W-1:0] m_prev;
    if (i == 0) begin : g_head
      assign w_prev = sample_r;
      assign m_prev = cell_m[WINDOW_SIZE-1];
    end else begin : g_body
      assign w_prev = cell_w[i-1];
      assign m_prev = cell_m[i-1];
    end
    mof_cell u_cell (
      .clk      (clk),
      .ctl      (cell_ctl),
      .fill_val (sample_r),
      .w_prev   (w_prev),
      .m_prev   (m_prev),
      .w        (cell_w[i]),
      .m        (cell_m[i]),
      .is_med   (cell_med[i])
    );
  end

  always_comb begin
    median = cell_w[0];
    for (int i = WINDOW_SIZE - 1; i >= 0; i--) begin
      if (cell_med[i]) begin
        median = cell_w[i];
      end
    end
  end

  assign diff       = {sample_r[SAMPLE_W-1], sample_r} - {held_r[SAMPLE_W-1], held_r};
  assign abs_diff   = diff[SAMPLE_W] ? (SAMPLE_W+1)'(-diff) : diff;
  assign outlier    = ready_r && (abs_diff > {(SAMPLE_W+1-MAX_JUMP_W)'(0), max_jump_r});
  assign streak_inc = (streak_r < STREAK_MAX) ? streak_r + CONFIRM_W'(1) : streak_r;
  assign fill_sat   = (fill_r < WIN_CNT) ? fill_r + CNT_W'(1) : fill_r;
  assign out_load   = (state_r == ST_OUT) && (!out_valid_r || out_tready);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (!outlier && fill_sat == WIN_CNT) begin
          state_nxt = ST_SORT;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_SORT: begin
        if (sort_cnt_r == LAST_CNT) begin
          state_nxt = ST_PICK;
        end
      end
      ST_PICK: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // outputs and datapath control
  always_comb begin
    cell_ctl      = '0;
    held_nxt      = held_r;
    streak_nxt    = streak_r;
    fill_nxt      = fill_r;
    ready_nxt     = ready_r;
    sort_cnt_nxt  = sort_cnt_r;
    flags_nxt     = flags_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_flags_nxt = out_flags_r;
    in_tready     = (state_r == ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
      end
      ST_EVAL: begin
        flags_nxt = '0;
        flags_nxt.filter_ready = ready_r;
        sort_cnt_nxt = '0;
        if (outlier) begin
          if (streak_inc < confirm_r) begin
            streak_nxt = streak_inc;
            flags_nxt.outlier_ignored = 1'b1;
          end else begin
            cell_ctl.fill            = 1'b1;
            held_nxt                 = sample_r;
            streak_nxt               = '0;
            fill_nxt                 = WIN_CNT;
            flags_nxt.reanchored     = 1'b1;
            flags_nxt.offset_updated = 1'b1;
          end
        end else begin
          if (ready_r) begin
            streak_nxt = '0;
          end
          cell_ctl.shift = 1'b1;
          cell_ctl.load  = 1'b1;
          fill_nxt       = fill_sat;
        end
      end
      ST_SORT: begin
        cell_ctl.step = 1'b1;
        sort_cnt_nxt  = sort_cnt_r + CNT_W'(1);
      end
      ST_PICK: begin
        held_nxt                 = median;
        ready_nxt                = 1'b1;
        flags_nxt.offset_updated = 1'b1;
        flags_nxt.filter_ready   = 1'b1;
      end
      ST_OUT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = held_r;
          out_flags_nxt = flags_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      max_jump_r  <= MAX_JUMP_RESET;
      confirm_r   <= CONFIRM_RESET;
      held_r      <= '0;
      streak_r    <= '0;
      fill_r      <= '0;
      ready_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      streak_r    <= streak_nxt;
      fill_r      <= fill_nxt;
      ready_r     <= ready_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        if (cfg_index == REG_MAX_JUMP) begin
          max_jump_r <= cfg_data[MAX_JUMP_W-1:0];
        end else if (cfg_index == REG_CONFIRM) begin
          confirm_r <= cfg_data[CONFIRM_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      sample_r <= in_tdata;
    end
    sort_cnt_r  <= sort_cnt_nxt;
    flags_r     <= flags_nxt;
    out_data_r  <= out_data_nxt;
    out_flags_r <= out_flags_nxt;
  end

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_flags_r;

endmodule

// ===== hw/rtl/mof_checker.sv =====
// Port-level checker for the median offset filter with outlier gate.
// Depends on mof_pkg; bound to median_offset_filter_outlier_gate below.
module mof_checker import mof_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [SAMPLE_W-1:0]   in_tdata,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [SAMPLE_W-1:0]   out_tdata,
  input logic [FLAGS_W-1:0]    out_tuser,
  input logic                  cfg_valid,
  input logic                  cfg_ready,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second request taken while one is in flight");

  a_ignored_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> !out_tuser[1] && !out_tuser[3] && out_tuser[0])
    else $error("ignored outlier flagged with an update");

  a_reanchor: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[3] |-> out_tuser[1] && out_tuser[0])
    else $error("re-anchor without update");

  a_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == '0 && out_tuser[3:1] == '0)
    else $error("offset published before window filled");

endmodule

bind median_offset_filter_outlier_gate mof_checker u_mof_checker (.*);

// ===== dv/median_offset_filter_outlier_gate_test.sv =====
// Testbench for median_offset_filter_outlier_gate: drives offset samples and limit writes,
// predicts every filter report in a model of the window and checks it field by field.
// Depends on mof_pkg and the filter RTL only.
`timescale 1ns / 1ps

module median_offset_filter_outlier_gate_test;
  import mof_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(3);
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam int RANDOM_PHASE_ITEMS = 185;
  localparam int SETTLE_CYCLES = 4 + WINDOW_SIZE;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] offset;
    mof_flags_t                 flags;
  } offset_report_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [SAMPLE_W-1:0]   in_tdata = '0;   // [63:0] offset_sample
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [SAMPLE_W-1:0]   out_tdata;       // [63:0] current_offset
  logic [FLAGS_W-1:0]    out_tuser;       // [0] filter_ready, [1] offset_updated,
                                          // [2] outlier_ignored, [3] reanchored
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  median_offset_filter_outlier_gate uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  logic signed [SAMPLE_W-1:0] win_samples [WINDOW_SIZE];
  int                         win_wptr;
  int                         win_fill;
  logic signed [SAMPLE_W-1:0] held_offset_q;
  logic                       filter_is_ready;
  logic [CONFIRM_W-1:0]       outlier_run;
  logic [MAX_JUMP_W-1:0]      gate_max_jump;
  logic [CONFIRM_W-1:0]       gate_confirm;

  offset_report_t pending_reports[$];
  int             mismatch_count = 0;
  int             sender_idle_pct = 0;
  int             receiver_stall_pct = 0;
  int             burst_left = 0;
  logic [SAMPLE_W-1:0] burst_base;

  function automatic offset_report_t predict_filter_step(logic signed [SAMPLE_W-1:0] s);
    offset_report_t             rep;
    logic signed [SAMPLE_W:0]   diff;
    logic [SAMPLE_W:0]          mag;
    logic signed [SAMPLE_W-1:0] sorted_win [WINDOW_SIZE];
    logic signed [SAMPLE_W-1:0] v;
    int                         i;
    int                         j;
    rep.flags = '0;
    diff = {s[SAMPLE_W-1], s} - {held_offset_q[SAMPLE_W-1], held_offset_q};
    mag = diff[SAMPLE_W] ? (~diff + 1'b1) : diff;
    if (filter_is_ready && mag > {33'b0, gate_max_jump}) begin
      if (outlier_run < STREAK_MAX) outlier_run = outlier_run + 1'b1;
      if (outlier_run < gate_confirm) begin
        rep.flags.outlier_ignored = 1'b1;
      end else begin
        for (i = 0; i < WINDOW_SIZE; i++) win_samples[i] = s;
        win_fill = WINDOW_SIZE;
        win_wptr = 0;
        held_offset_q = s;
        outlier_run = '0;
        rep.flags.offset_updated = 1'b1;
        rep.flags.reanchored = 1'b1;
      end
    end else begin
      if (filter_is_ready) outlier_run = '0;
      win_samples[win_wptr] = s;
      win_wptr = (win_wptr + 1) % WINDOW_SIZE;
      if (win_fill < WINDOW_SIZE) win_fill++;
      if (win_fill >= WINDOW_SIZE) begin
        for (i = 0; i < WINDOW_SIZE; i++) sorted_win[i] = win_samples[i];
        for (i = 1; i < WINDOW_SIZE; i++) begin
          v = sorted_win[i];
          j = i - 1;
          while (j >= 0 && sorted_win[j] > v) begin
            sorted_win[j + 1] = sorted_win[j];
            j--;
          end
          sorted_win[j + 1] = v;
        end
        held_offset_q = sorted_win[WINDOW_SIZE / 2];
        filter_is_ready = 1'b1;
        rep.flags.offset_updated = 1'b1;
      end
    end
    rep.offset = held_offset_q;
    rep.flags.filter_ready = filter_is_ready;
    return rep;
  endfunction

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
    int gap;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= s;
    do @(posedge clk); while (!in_tready);
    pending_reports.push_back(predict_filter_step(s));
  endtask

  task automatic hold_until_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_reports.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_MAX_JUMP) gate_max_jump = data;
    else if (idx == REG_CONFIRM) gate_confirm = data[CONFIRM_W-1:0];
  endtask

  task automatic set_limits(input logic [CFG_DATA_W-1:0] max_jump,
                            input logic [CFG_DATA_W-1:0] confirm_word, input bit poke_spare);
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_MAX_JUMP, max_jump);
    write_reg(REG_CONFIRM, confirm_word);
    if (poke_spare) write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, $urandom);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] next_random_sample();
    logic [SAMPLE_W-1:0] span;
    logic [SAMPLE_W-1:0] step;
    int                  r;
    span = {32'b0, gate_max_jump};
    if (burst_left > 0) begin
      burst_left--;
      return burst_base + 64'($urandom_range(0, 3));
    end
    r = $urandom_range(99);
    if (r < 6) return {$urandom, $urandom};
    if (r < 14) begin
      step = span + 64'($urandom_range(1));
      return $urandom_range(1) ? held_offset_q + step : held_offset_q - step;
    end
    if (r < 34) begin
      step = span + 1 + 64'($urandom_range(0, 1000000));
      burst_base = $urandom_range(1) ? held_offset_q + step : held_offset_q - step;
      burst_left = $urandom_range(0, gate_confirm);
      return burst_base;
    end
    step = {$urandom, $urandom} % (span + 1);
    return $urandom_range(1) ? held_offset_q + step : held_offset_q - step;
  endfunction

  task automatic test_fill_and_gate();
    int i;
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    send_sample(64'sd0);
    send_sample(-64'sd1);
    send_sample(64'sd1);
    send_sample(64'sd1000);
    send_sample(-64'sd1000);
    send_sample(64'sd5);
    send_sample(held_offset_q + gate_max_jump);
    send_sample(held_offset_q - gate_max_jump);
    send_sample(held_offset_q + gate_max_jump + 1);
    send_sample(held_offset_q);
    for (i = 0; i < 3; i++) send_sample(-64'sd500000 - i);
    for (i = 0; i < 3; i++) send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MIN);
  endtask

  task automatic test_register_extremes();
    set_limits(32'h0, 32'hFFFF_FF00, 1'b1);
    send_sample(held_offset_q);
    send_sample(held_offset_q + 1);
    send_sample(held_offset_q - 1);
    send_sample(held_offset_q);
    set_limits(32'h0, 32'h1, 1'b0);
    send_sample(held_offset_q + 64'sd77);
  endtask

  task automatic test_streak_limit();
    int i;
    set_limits(32'hFFFF_FFFF, 32'hFF, 1'b1);
    send_sample(SAMPLE_MAX - 64'sh1_0000_0000);
    send_sample(held_offset_q - 64'sh1_0000_0000);
    for (i = 0; i < 255; i++) send_sample(held_offset_q + 64'sh2_0000_0000 + i);
    for (i = 0; i < 10; i++) send_sample(held_offset_q - 64'sh3_0000_0000);
    set_limits(32'hFFFF_FFFF, 32'h5, 1'b0);
    send_sample(held_offset_q - 64'sh3_0000_0000);
  endtask

  task automatic run_random_phase(input int idle_pct, input int stall_pct,
                                  input logic [CFG_DATA_W-1:0] max_jump,
                                  input logic [CFG_DATA_W-1:0] confirm_word, input bit pause_mid);
    int n;
    set_limits(max_jump, confirm_word, 1'b1);
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    burst_left = 0;
    for (n = 0; n < RANDOM_PHASE_ITEMS; n++) begin
      if (pause_mid && n == RANDOM_PHASE_ITEMS / 2) hold_until_drained();
      send_sample(next_random_sample());
    end
  endtask

  task automatic test_random_traffic();
    run_random_phase(0, 0, 32'd180000, 32'd3, 1'b0);
    run_random_phase(71, 0, 32'($urandom_range(0, 65535)), 32'd1, 1'b1);
    run_random_phase(0, 71, 32'h0, 32'd2, 1'b0);
    run_random_phase(10, 10, 32'hFFFF_FFFF, 32'($urandom_range(1, 5)), 1'b0);
  endtask

  always @(posedge clk) out_tready <= ($urandom_range(99) >= receiver_stall_pct);

  always @(posedge clk) begin
    offset_report_t want;
    offset_report_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.offset = out_tdata;
      got.flags = out_tuser;
      if (pending_reports.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected report: offset %0d flags %b", got.offset, got.flags);
      end else begin
        want = pending_reports.pop_front();
        if (got.offset !== want.offset ||
            got.flags.filter_ready !== want.flags.filter_ready ||
            got.flags.offset_updated !== want.flags.offset_updated ||
            got.flags.outlier_ignored !== want.flags.outlier_ignored ||
            got.flags.reanchored !== want.flags.reanchored) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("report mismatch: expected offset %0d flags %b, got offset %0d flags %b",
                     want.offset, want.flags, got.offset, got.flags);
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < WINDOW_SIZE; i++) win_samples[i] = '0;
    win_wptr = 0;
    win_fill = 0;
    held_offset_q = '0;
    filter_is_ready = 1'b0;
    outlier_run = '0;
    gate_max_jump = MAX_JUMP_RESET;
    gate_confirm = CONFIRM_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_fill_and_gate();
    test_register_extremes();
    test_streak_limit();
    test_random_traffic();
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_reports.size() == 0) begin
      $display("median_offset_filter_outlier_gate_test: PASS");
    end else begin
      $display("median_offset_filter_outlier_gate_test: FAIL");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("median_offset_filter_outlier_gate_test: FAIL");
    $finish;
  end

endmodule
